// ===== rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants and types of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int BYTE_W          = 8;
  localparam int PATTERN_SLOTS   = 32;
  localparam int SLOT_IDX_W      = $clog2(PATTERN_SLOTS);
  localparam int LEN_W           = 6;
  localparam int CARE_W          = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int MAX_PATTERN_DEF = 32;
  localparam int ADDR_W_DEF      = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 3'd5;

  // control shared by every history cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== rtl/mbps_cfg.sv =====
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration registers and the pattern view aligned to history depth.
// ----------------------------------------------------------------------------
module mbps_cfg
  import mbps_pkg::*;
#(
  parameter int NCELL = MAX_PATTERN_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output logic [NCELL*BYTE_W-1:0] pat_al,
  output logic [NCELL-1:0]        care_al,
  output logic [NCELL-1:0]        need_al,
  output logic [SLOT_IDX_W-1:0]   len_m1
);

  logic [PATTERN_SLOTS*BYTE_W-1:0] pat_r;
  logic [CARE_W-1:0]               care_r;
  logic [LEN_W-1:0]                len_r;

  logic [LEN_W-1:0]                len_sat;
  logic [SLOT_IDX_W-1:0]           sh;
  logic [PATTERN_SLOTS*BYTE_W-1:0] pat_rev;
  logic [PATTERN_SLOTS-1:0]        care_rev;
  logic [PATTERN_SLOTS*BYTE_W-1:0] pat_sh;
  logic [PATTERN_SLOTS-1:0]        care_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      care_r <= '0;
      len_r  <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_0:   pat_r[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_PATTERN_1:   pat_r[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_PATTERN_2:   pat_r[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_PATTERN_3:   pat_r[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        REG_CARE_MASK:   care_r <= cfg_wdata[CARE_W-1:0];
        REG_PATTERN_LEN: len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, above the cell count is clamped
  always_comb begin
    len_sat = len_r;
    if (len_r == '0) begin
      len_sat = LEN_W'(1);
    end else if (len_r > LEN_W'(NCELL)) begin
      len_sat = LEN_W'(NCELL);
    end
    len_m1 = SLOT_IDX_W'(len_sat - LEN_W'(1));
    sh     = SLOT_IDX_W'(PATTERN_SLOTS - 1) - len_m1;
  end

  // slot k of the aligned view is pattern position len-1-k, i.e. history depth k
  always_comb begin
    for (int j = 0; j < PATTERN_SLOTS; j++) begin
      pat_rev[j*BYTE_W +: BYTE_W] = pat_r[(PATTERN_SLOTS-1-j)*BYTE_W +: BYTE_W];
      care_rev[j]                 = care_r[PATTERN_SLOTS-1-j];
    end
    pat_sh  = pat_rev >> {sh, 3'b000};
    care_sh = care_rev >> sh;
  end

  assign pat_al  = pat_sh[NCELL*BYTE_W-1:0];
  assign care_al = care_sh[NCELL-1:0];

  // a depth must hold a region byte when some care position lies at or before it
  always_comb begin
    for (int k = 0; k < NCELL; k++) begin
      need_al[k] = |(care_sh >> k);
    end
  end

endmodule

// ===== rtl/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// mbps_cell
// One history cell: a byte of the window, its valid flag and its compare.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] prev_byte,
  input  logic              prev_vld,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              care,
  input  logic              need,
  output logic [BYTE_W-1:0] byte_r,
  output logic              vld_r,
  output logic              ok
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= ctl.clear ? 1'b0 : prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= prev_byte;
    end
  end

  assign ok = !need || (vld_r && (!care || (byte_r == pat_byte)));

endmodule

// ===== rtl/masked_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Masked byte pattern search over a byte stream, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while in_stall is low, with no gaps of its own.
// The window is a row of history cells, one byte each, shifted on every input
// transfer; all cells compare against the aligned pattern in parallel and the
// match is formed in the cycle the byte is taken. The match address is registered
// in the output register, or in the skid while it is held. A two-entry output
// buffer (output register plus skid) lets input keep flowing while a result waits;
// in_stall rises only when both entries are full. The pattern view is built from
// the configuration registers directly, so a write applies to the byte after it.
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int ADDRESS_WIDTH = ADDR_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_data_byte,
  input  logic [ADDRESS_WIDTH-1:0] in_byte_address,
  input  logic                     in_final_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ADDRESS_WIDTH-1:0] out_match_address
);

  localparam int NCELL = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;

  logic [NCELL*BYTE_W-1:0] pat_al;
  logic [NCELL-1:0]        care_al;
  logic [NCELL-1:0]        need_al;
  logic [SLOT_IDX_W-1:0]   len_m1;

  logic [BYTE_W-1:0]       chain_byte [NCELL];
  logic [NCELL-1:0]        chain_vld;
  logic [NCELL-1:0]        ok_vec;
  cell_ctl_t               ctl;

  logic                     in_acc;
  logic                     hit;
  logic [ADDRESS_WIDTH-1:0] res_addr;
  logic                     out_take;

  logic                     out_vld_r;
  logic [ADDRESS_WIDTH-1:0] out_addr_r;
  logic                     skid_vld_r;
  logic [ADDRESS_WIDTH-1:0] skid_addr_r;

  mbps_cfg #(
    .NCELL(NCELL)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .pat_al   (pat_al),
    .care_al  (care_al),
    .need_al  (need_al),
    .len_m1   (len_m1)
  );

  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid && !in_stall;
  assign ctl.shift = in_acc;
  assign ctl.clear = in_final_byte;

  // depth zero is the incoming byte itself
  assign chain_byte[0] = in_data_byte;
  assign chain_vld[0]  = 1'b1;
  assign ok_vec[0]     = !need_al[0] || !care_al[0] ||
                         (in_data_byte == pat_al[0 +: BYTE_W]);

  for (genvar k = 1; k < NCELL; k++) begin : g_cell
    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_byte(chain_byte[k-1]),
      .prev_vld (chain_vld[k-1]),
      .pat_byte (pat_al[k*BYTE_W +: BYTE_W]),
      .care     (care_al[k]),
      .need     (need_al[k]),
      .byte_r   (chain_byte[k]),
      .vld_r    (chain_vld[k]),
      .ok       (ok_vec[k])
    );
  end

  assign hit      = in_acc && (&ok_vec);
  assign res_addr = in_byte_address - ADDRESS_WIDTH'(len_m1);
  assign out_take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_take) begin
      out_vld_r <= hit;
    end else if (hit) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_addr_r <= skid_addr_r;
      end
    end else if (!out_vld_r || out_take) begin
      out_addr_r <= res_addr;
    end else if (hit) begin
      skid_addr_r <= res_addr;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_match_address = out_addr_r;

  // a result waits in the skid only behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry without an output entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid filled while output was free");

  // valid history bytes form a run from the most recent one
  a_hist_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    ((chain_vld >> 1) & ((chain_vld >> 1) + NCELL'(1))) == '0)
    else $error("history valid flags not contiguous");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_final_byte) |=> (chain_vld >> 1) == '0)
    else $error("history not cleared after final byte");

endmodule

// ===== dv/masked_byte_pattern_scanner_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb
// Self-checking bench for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
// A queue-fed driver streams bytes into the scanner, with random gaps. A
// random stall is applied on the match side. The monitor runs a shadow
// scanner on every input transfer and checks each match address against the
// oldest predicted start address. Configurations cover the register extremes:
// all-wildcard masks, clamped and zero lengths, full 32-byte patterns, and
// overlapping runs. Pattern copies are embedded in regions so that matches
// are frequent.
module masked_byte_pattern_scanner_tb;
  import mbps_pkg::*;

  localparam int ADDR_W      = ADDR_W_DEF;
  localparam int HIST_D      = MAX_PATTERN_DEF - 1;
  localparam int LEN_CAP     = (MAX_PATTERN_DEF < PATTERN_SLOTS) ? MAX_PATTERN_DEF
                                                                   : PATTERN_SLOTS;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic [ADDR_W-1:0] addr;
    logic              fin;
  } scan_item_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = REG_PATTERN_0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_byte    = '0;
  logic [ADDR_W-1:0]     in_byte_address = '0;
  logic                  in_final_byte   = 1'b0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [ADDR_W-1:0]     out_match_address;

  // shadow of the configuration registers
  logic [8*PATTERN_SLOTS-1:0] pattern_cfg = '0;
  logic [CARE_W-1:0]          care_cfg    = '0;
  logic [LEN_W-1:0]           len_cfg     = 6'd1;

  // shadow of the scan window
  logic [BYTE_W-1:0] window_hist [HIST_D];
  int                window_fill = 0;

  scan_item_t        byte_q[$];
  logic [ADDR_W-1:0] match_start_q[$];
  scan_item_t        drv_item;
  int                bytes_queued = 0;
  int                bytes_taken  = 0;
  int                failures     = 0;
  int                stuck_cycles = 0;
  bit                no_gaps      = 1'b0;

  masked_byte_pattern_scanner #(
    .MAX_PATTERN   (MAX_PATTERN_DEF),
    .ADDRESS_WIDTH (ADDR_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_address   (in_byte_address),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_address (out_match_address)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (window_hist[k]) window_hist[k] = '0;
  end

  function automatic int scan_len();
    int len;
    len = len_cfg;
    if (len == 0) len = 1;
    if (len > LEN_CAP) len = LEN_CAP;
    return len;
  endfunction

  function automatic int first_care();
    int lead;
    int len;
    len = scan_len();
    lead = 0;
    while (lead < len && !care_cfg[lead]) lead++;
    return lead;
  endfunction

  // shadow scanner: examine one byte, then update the window
  function automatic bit scan_step(input logic [BYTE_W-1:0] cur,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic fin,
                                   output logic [ADDR_W-1:0] match_start);
    int len;
    int lead;
    int back;
    bit hit;
    logic [BYTE_W-1:0] b;
    len  = scan_len();
    lead = first_care();
    // positions from the first cared byte on must lie inside the region
    hit = (lead == len) || (len - 1 - lead <= window_fill);
    for (int i = lead; hit && i < len; i++) begin
      if (care_cfg[i]) begin
        back = len - 1 - i;
        b = (back == 0) ? cur : window_hist[back-1];
        if (b != pattern_cfg[i*8 +: 8]) hit = 1'b0;
      end
    end
    match_start = addr - ADDR_W'(len - 1);
    if (fin) begin
      foreach (window_hist[k]) window_hist[k] = '0;
      window_fill = 0;
    end else begin
      for (int k = HIST_D - 1; k > 0; k--) window_hist[k] = window_hist[k-1];
      window_hist[0] = cur;
      if (window_fill < HIST_D) window_fill++;
    end
    return hit;
  endfunction

  // driver: hold a stalled byte, otherwise take the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (byte_q.size() != 0 && (no_gaps || $urandom_range(99) >= 15)) begin
        drv_item = byte_q.pop_front();
        in_valid        <= 1'b1;
        in_data_byte    <= drv_item.data;
        in_byte_address <= drv_item.addr;
        in_final_byte   <= drv_item.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 15);
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    logic [ADDR_W-1:0] predicted;
    logic [ADDR_W-1:0] wanted;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (scan_step(in_data_byte, in_byte_address, in_final_byte, predicted))
          match_start_q.insert(match_start_q.size(), predicted);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (match_start_q.size() == 0) begin
          $error("match_address: expected none, got %h", out_match_address);
          failures++;
        end else begin
          wanted = match_start_q.pop_front();
          if (out_match_address !== wanted) begin
            $error("match_address: expected %h, got %h", wanted, out_match_address);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] d, input logic [ADDR_W-1:0] a,
                           input logic f);
    scan_item_t item;
    item = '{data: d, addr: a, fin: f};
    byte_q.insert(byte_q.size(), item);
    bytes_queued++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic program_scanner(input logic [8*PATTERN_SLOTS-1:0] pat,
                                 input logic [CARE_W-1:0] care,
                                 input logic [LEN_W-1:0] len);
    cfg_write(REG_PATTERN_0, pat[63:0]);
    cfg_write(REG_PATTERN_1, pat[127:64]);
    cfg_write(REG_PATTERN_2, pat[191:128]);
    cfg_write(REG_PATTERN_3, pat[255:192]);
    cfg_write(REG_CARE_MASK, CFG_DATA_W'(care));
    cfg_write(REG_PATTERN_LEN, CFG_DATA_W'(len));
    @(posedge clk);
    cfg_we <= 1'b0;
    pattern_cfg = pat;
    care_cfg    = care;
    len_cfg     = len;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || match_start_q.size() != 0) @(negedge clk);
    // output register plus skid entry
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [8*PATTERN_SLOTS-1:0] rand_pattern();
    logic [8*PATTERN_SLOTS-1:0] p;
    for (int w = 0; w < 8; w++) p[w*32 +: 32] = $urandom;
    return p;
  endfunction

  // regions of embedded pattern copies (some cut short or corrupted) and noise
  task automatic fill_phase(input int n_bytes);
    int made;
    int chunks;
    int len;
    int first;
    int cut;
    int bad;
    int n;
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] d;
    made = 0;
    len  = scan_len();
    while (made < n_bytes) begin
      case ($urandom_range(9))
        0:       a = '1 - ADDR_W'($urandom_range(40));
        1:       a = ADDR_W'($urandom_range(40));
        default: a = ADDR_W'({$urandom, $urandom});
      endcase
      chunks = $urandom_range(1, 4);
      for (int c = 0; c < chunks; c++) begin
        if ($urandom_range(9) < 7) begin
          // leading wildcards may be left out at the start of a region
          first = (c == 0 && $urandom_range(2) == 0) ? first_care() : 0;
          if (first >= len) first = 0;
          cut = ($urandom_range(9) == 0) ? $urandom_range(first + 1, len) : len;
          bad = ($urandom_range(7) == 0) ? $urandom_range(first, len - 1) : -1;
          for (int j = first; j < cut; j++) begin
            d = care_cfg[j] ? pattern_cfg[j*8 +: 8] : BYTE_W'($urandom);
            if (j == bad) d = d ^ (8'h01 << $urandom_range(7));
            push_byte(d, a, 1'b0);
            a++;
            made++;
          end
        end else begin
          n = $urandom_range(0, 6);
          for (int j = 0; j < n; j++) begin
            d = $urandom_range(1) ? BYTE_W'($urandom)
                                  : pattern_cfg[$urandom_range(PATTERN_SLOTS-1)*8 +: 8];
            push_byte(d, a, 1'b0);
            a++;
            made++;
          end
        end
      end
      push_byte(BYTE_W'($urandom), a, $urandom_range(4) != 0);
      made++;
    end
  endtask

  initial begin
    logic [8*PATTERN_SLOTS-1:0] pat;
    logic [CARE_W-1:0]          care;
    logic [LEN_W-1:0]           len;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: one wildcard position, every byte matches
    push_byte(8'h00, '0, 1'b0);
    push_byte(8'hFF, '1, 1'b0);
    push_byte(8'hA5, 48'h123, 1'b1);
    wait_idle();

    // four cared bytes, start address wrapping below zero
    program_scanner(256'hEFBEADDE, 32'h0000000F, 6'd4);
    push_byte(8'hDE, '1 - 1, 1'b0);
    push_byte(8'hAD, '1, 1'b0);
    push_byte(8'hBE, 48'h0, 1'b0);
    push_byte(8'hEF, 48'h1, 1'b0);
    push_byte(8'h00, 48'h2, 1'b1);
    // region ends inside the pattern: no match across the final byte
    push_byte(8'hDE, 48'h100, 1'b0);
    push_byte(8'hAD, 48'h101, 1'b1);
    push_byte(8'hBE, 48'h102, 1'b0);
    push_byte(8'hEF, 48'h103, 1'b0);
    push_byte(8'h55, 48'h104, 1'b1);
    wait_idle();

    // leading wildcards unseen, trailing wildcard must be seen
    program_scanner(256'h2211_0000, 32'h0000000C, 6'd5);
    push_byte(8'h11, 48'h10, 1'b0);
    push_byte(8'h22, 48'h11, 1'b0);
    push_byte(8'h77, 48'h12, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin pat = rand_pattern(); care = '1; len = 6'd32; end
        1: begin pat = '1; care = $urandom; len = 6'd63; end
        2: begin pat = rand_pattern(); care = $urandom; len = 6'd0; end
        3: begin pat = '0; care = '1; len = 6'd2; end
        4: begin pat = {PATTERN_SLOTS{8'hAA}}; care = 32'h7; len = 6'd3; end
        5: begin pat = rand_pattern(); care = '0; len = 6'd32; end
        default: begin
          pat  = rand_pattern();
          care = $urandom;
          len  = LEN_W'($urandom_range(1, 8));
        end
      endcase
      program_scanner(pat, care, len);
      no_gaps = (ph == 5);
      fill_phase(42);
      wait_idle();
      no_gaps = 1'b0;
    end

    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mbps_pkg.sv
rtl/mbps_cfg.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_scanner.sv
dv/masked_byte_pattern_scanner_tb.sv
